>>> design/qbdp_pkg.sv
// qbdp_pkg: shared types and constants for the block-quantised dot product
// holds the controller state and operation enums and the command and status structs
// no dependencies
package qbdp_pkg;

   localparam int BLOCK_ITEMS = 16;
   localparam int CNT_W       = $clog2(BLOCK_ITEMS);

   localparam logic [1:0] FMT_Q4   = 2'd0;
   localparam logic [1:0] FMT_Q5   = 2'd1;
   localparam logic [1:0] FMT_HALF = 2'd2;

   localparam int Q4_BIAS    = 8;
   localparam int Q5_BIAS    = 16;
   localparam int EXP_OFFSET = 17;

   localparam logic [4:0] EXP_SPECIAL = 5'd31;

   localparam logic signed [63:0] SUM_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
   localparam logic signed [63:0] SUM_MIN = 64'sh8000_0000_0000_0000;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ACC,
      ST_SC_MUL,
      ST_SC_SHIFT,
      ST_SC_ADD,
      ST_END_CHK,
      ST_EMIT
   } state_type;

   typedef enum logic [1:0] {
      OP_BLOCK_MID,
      OP_BLOCK_END,
      OP_HALF_A,
      OP_HALF_B
   } op_type;

   typedef enum logic [1:0] {
      SRC_BLOCK,
      SRC_ACT_A,
      SRC_ACT_B
   } src_type;

   typedef struct packed {
      logic    load_item;
      logic    block_acc;
      src_type sc_src;
      logic    sc_mul;
      logic    sc_shift;
      logic    sc_add;
      logic    blk_clear;
      logic    rsp_load;
   } cmd_type;

   typedef struct packed {
      logic [1:0] fmt;
      logic       block_full;
      logic       block_pending;
      logic       row_last;
      logic       rsp_free;
   } status_type;

endpackage

>>> design/qbdp_ctrl.sv
// qbdp_ctrl: sequencing state machine for the block-quantised dot product
// issues datapath commands per item, block flush and row end
// depends on qbdp_pkg
module qbdp_ctrl
   import qbdp_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  status_type status,
   output cmd_type    cmd
);

   state_type state_ff, state_in;
   op_type    op_ff, op_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         op_ff    <= OP_BLOCK_MID;
      end else begin
         state_ff <= state_in;
         op_ff    <= op_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      op_in    = op_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               case (status.fmt)
                  FMT_Q4, FMT_Q5: begin
                     state_in = ST_ACC;
                  end
                  FMT_HALF: begin
                     state_in = ST_SC_MUL;
                     op_in    = OP_HALF_A;
                  end
                  default: begin
                     state_in = ST_END_CHK;
                  end
               endcase
            end
         end
         ST_ACC: begin
            if (status.block_full) begin
               state_in = ST_SC_MUL;
               op_in    = OP_BLOCK_MID;
            end else begin
               state_in = ST_END_CHK;
            end
         end
         ST_SC_MUL: begin
            state_in = ST_SC_SHIFT;
         end
         ST_SC_SHIFT: begin
            state_in = ST_SC_ADD;
         end
         ST_SC_ADD: begin
            case (op_ff)
               OP_HALF_A: begin
                  state_in = ST_SC_MUL;
                  op_in    = OP_HALF_B;
               end
               OP_BLOCK_END: begin
                  state_in = ST_EMIT;
               end
               default: begin
                  state_in = ST_END_CHK;
               end
            endcase
         end
         ST_END_CHK: begin
            if (!status.row_last) begin
               state_in = ST_IDLE;
            end else if (status.block_pending) begin
               state_in = ST_SC_MUL;
               op_in    = OP_BLOCK_END;
            end else begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (status.rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      cmd        = '0;
      cmd.sc_src = SRC_BLOCK;
      req_tready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_tready    = 1'b1;
            cmd.load_item = req_tvalid;
         end
         ST_ACC: begin
            cmd.block_acc = 1'b1;
         end
         ST_SC_MUL: begin
            cmd.sc_mul = 1'b1;
            case (op_ff)
               OP_HALF_A: cmd.sc_src = SRC_ACT_A;
               OP_HALF_B: cmd.sc_src = SRC_ACT_B;
               default:   cmd.sc_src = SRC_BLOCK;
            endcase
         end
         ST_SC_SHIFT: begin
            cmd.sc_shift = 1'b1;
         end
         ST_SC_ADD: begin
            cmd.sc_add    = 1'b1;
            cmd.blk_clear = (op_ff == OP_BLOCK_MID) || (op_ff == OP_BLOCK_END);
         end
         ST_EMIT: begin
            cmd.rsp_load = status.rsp_free;
         end
         default: begin
            cmd.sc_src = SRC_BLOCK;
         end
      endcase
   end

   // half-precision item runs its first term through the scaler straight away
   a_half_start: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE && req_tvalid && status.fmt == FMT_HALF)
      |=> (state_ff == ST_SC_MUL && op_ff == OP_HALF_A))
      else $error("half item did not start scaling of first term");

   a_end_flush: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SC_ADD && op_ff == OP_BLOCK_END) |=> (state_ff == ST_EMIT))
      else $error("row end flush not followed by result load");

endmodule

>>> design/qbdp_datapath.sv
// qbdp_datapath: item registers, block accumulator, three-stage scaler, row sum and result register
// executes commands from qbdp_ctrl and returns status
// depends on qbdp_pkg
module qbdp_datapath
   import qbdp_pkg::*;
#(
   parameter int  ACT_WIDTH = 24,
   localparam int REQ_W     = ((58 + 2 * ACT_WIDTH + 7) / 8) * 8
)
(
   input  logic             clock,
   input  logic             reset,
   input  logic [REQ_W-1:0] req_tdata,
   input  logic             req_tlast,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [1:0]       csr_data,
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output logic [63:0]      rsp_tdata,
   output logic [1:0]       rsp_tuser,
   input  cmd_type          cmd,
   output status_type       status
);

   localparam int OFF_SCALE = 0;
   localparam int OFF_CODE  = 16;
   localparam int OFF_F5L   = 24;
   localparam int OFF_F5H   = 25;
   localparam int OFF_HA    = 26;
   localparam int OFF_HB    = 42;
   localparam int OFF_ACTA  = 58;
   localparam int OFF_ACTB  = 58 + ACT_WIDTH;
   localparam int BSW       = ACT_WIDTH + 10;
   localparam int PW        = BSW + 13;
   localparam int SHW       = (PW + 13 > 65) ? PW + 13 : 65;

   logic [1:0] fmt_ff;

   logic [15:0]                 scale_it_ff;
   logic [7:0]                  code_ff;
   logic                        f5l_ff, f5h_ff;
   logic [15:0]                 ha_ff, hb_ff;
   logic signed [ACT_WIDTH-1:0] acta_ff, actb_ff;
   logic                        last_ff;

   logic signed [BSW-1:0] block_sum_ff, block_sum_in;
   logic [CNT_W-1:0]      cnt_ff;
   logic [15:0]           held_ff;

   logic signed [PW-1:0] prod_ff, prod_in;
   logic [5:0]           sh_ff, sh_in;
   logic                 spec_ff;

   logic signed [63:0] term_ff, term_in;
   logic               term_sat;

   logic signed [63:0] row_sum_ff, row_sum_in;
   logic               row_sat;
   logic               sat_seen_ff, spec_seen_ff;

   logic        rsp_valid_ff;
   logic [63:0] rsp_data_ff;
   logic [1:0]  rsp_user_ff;

   // configuration
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         fmt_ff <= FMT_Q4;
      end else if (csr_valid && csr_ready) begin
         fmt_ff <= csr_data;
      end
   end

   // item capture
   always_ff @(posedge clock) begin
      if (cmd.load_item) begin
         scale_it_ff <= req_tdata[OFF_SCALE +: 16];
         code_ff     <= req_tdata[OFF_CODE +: 8];
         f5l_ff      <= req_tdata[OFF_F5L];
         f5h_ff      <= req_tdata[OFF_F5H];
         ha_ff       <= req_tdata[OFF_HA +: 16];
         hb_ff       <= req_tdata[OFF_HB +: 16];
         acta_ff     <= $signed(req_tdata[OFF_ACTA +: ACT_WIDTH]);
         actb_ff     <= $signed(req_tdata[OFF_ACTB +: ACT_WIDTH]);
         last_ff     <= req_tlast;
      end
   end

   // block accumulation
   logic signed [5:0]           lo_w, hi_w;
   logic signed [ACT_WIDTH+5:0] prod_lo, prod_hi;

   always_comb begin
      if (fmt_ff == FMT_Q5) begin
         lo_w = $signed({1'b0, f5l_ff, code_ff[3:0]} - 6'(Q5_BIAS));
         hi_w = $signed({1'b0, f5h_ff, code_ff[7:4]} - 6'(Q5_BIAS));
      end else begin
         lo_w = $signed({2'b00, code_ff[3:0]} - 6'(Q4_BIAS));
         hi_w = $signed({2'b00, code_ff[7:4]} - 6'(Q4_BIAS));
      end
      prod_lo      = lo_w * acta_ff;
      prod_hi      = hi_w * actb_ff;
      block_sum_in = block_sum_ff + BSW'(prod_lo) + BSW'(prod_hi);
   end

   always_ff @(posedge clock) begin
      if (reset || cmd.rsp_load) begin
         block_sum_ff <= '0;
         cnt_ff       <= '0;
         held_ff      <= '0;
      end else if (cmd.blk_clear) begin
         block_sum_ff <= '0;
         cnt_ff       <= '0;
      end else if (cmd.block_acc) begin
         block_sum_ff <= block_sum_in;
         if (cnt_ff == '0) begin
            held_ff <= scale_it_ff;
         end
         if (cnt_ff != CNT_W'(BLOCK_ITEMS - 1)) begin
            cnt_ff <= cnt_ff + 1'b1;
         end
      end
   end

   // scaler stage one: mantissa product and shift amount
   logic signed [BSW-1:0]    op_v;
   logic [15:0]              op_h;
   logic [4:0]               ex;
   logic [10:0]              mant;
   logic [4:0]               e_eff;
   logic signed [BSW+11:0]   mp;

   always_comb begin
      case (cmd.sc_src)
         SRC_ACT_A: begin
            op_v = BSW'(acta_ff);
            op_h = ha_ff;
         end
         SRC_ACT_B: begin
            op_v = BSW'(actb_ff);
            op_h = hb_ff;
         end
         default: begin
            op_v = block_sum_ff;
            op_h = held_ff;
         end
      endcase
      ex      = op_h[14:10];
      mant    = (ex == '0) ? {1'b0, op_h[9:0]} : {1'b1, op_h[9:0]};
      e_eff   = (ex == '0) ? 5'd1 : ex;
      sh_in   = {1'b0, e_eff} - 6'(EXP_OFFSET);
      mp      = op_v * $signed({1'b0, mant});
      prod_in = op_h[15] ? -PW'(mp) : PW'(mp);
   end

   always_ff @(posedge clock) begin
      if (cmd.sc_mul) begin
         prod_ff <= prod_in;
         sh_ff   <= sh_in;
         spec_ff <= (ex == EXP_SPECIAL);
      end
   end

   // scaler stage two: floor right shift or saturating left shift, zero for a special exponent
   logic [4:0]            rs;
   logic [3:0]            ls;
   logic signed [PW-1:0]  shr;
   logic signed [SHW-1:0] shl;
   logic                  shl_fits;

   always_comb begin
      rs       = 5'(6'd0 - sh_ff);
      ls       = sh_ff[3:0];
      shr      = prod_ff >>> rs;
      shl      = SHW'(prod_ff) <<< ls;
      shl_fits = (shl[SHW-1:63] == '0) || (shl[SHW-1:63] == '1);
      term_sat = 1'b0;
      if (spec_ff) begin
         term_in = '0;
      end else if (sh_ff[5]) begin
         term_in = 64'(shr);
      end else if (shl_fits) begin
         term_in = shl[63:0];
      end else begin
         term_sat = 1'b1;
         term_in  = prod_ff[PW-1] ? SUM_MIN : SUM_MAX;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.sc_shift) begin
         term_ff <= term_in;
      end
   end

   // scaler stage three: saturating row add
   logic signed [64:0] sum_w;

   always_comb begin
      sum_w   = {row_sum_ff[63], row_sum_ff} + {term_ff[63], term_ff};
      row_sat = (sum_w[64] != sum_w[63]);
      if (row_sat) begin
         row_sum_in = sum_w[64] ? SUM_MIN : SUM_MAX;
      end else begin
         row_sum_in = sum_w[63:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset || cmd.rsp_load) begin
         row_sum_ff   <= '0;
         sat_seen_ff  <= 1'b0;
         spec_seen_ff <= 1'b0;
      end else begin
         if (cmd.sc_shift) begin
            if (spec_ff) begin
               spec_seen_ff <= 1'b1;
            end
            if (term_sat) begin
               sat_seen_ff <= 1'b1;
            end
         end
         if (cmd.sc_add) begin
            row_sum_ff <= row_sum_in;
            if (row_sat) begin
               sat_seen_ff <= 1'b1;
            end
         end
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rsp_load) begin
         rsp_data_ff <= row_sum_ff;
         rsp_user_ff <= {spec_seen_ff, sat_seen_ff};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

   always_comb begin
      status.fmt           = fmt_ff;
      status.block_full    = (cnt_ff == CNT_W'(BLOCK_ITEMS - 1));
      status.block_pending = (cnt_ff != '0) || (block_sum_ff != '0);
      status.row_last      = last_ff;
      status.rsp_free      = !rsp_valid_ff || rsp_tready;
   end

   a_row_cleared: assert property (@(posedge clock) disable iff (reset)
      cmd.rsp_load |=> (rsp_tvalid && row_sum_ff == '0 && !sat_seen_ff && !spec_seen_ff))
      else $error("row state not cleared after result load");

   a_block_cleared: assert property (@(posedge clock) disable iff (reset)
      cmd.blk_clear |=> (cnt_ff == '0 && block_sum_ff == '0))
      else $error("block accumulator not cleared after flush");

endmodule

>>> design/quantized_block_dot_product.sv
// quantized_block_dot_product: row dot product over four-bit, five-bit or half-precision weights
// block modes: an item is transferred, accumulated and row-checked, plus a scaler pass when it
// closes a block; a half-precision item takes two passes of the three-stage scaler; on row end
// a partial block adds one pass; the result loads once the output is free, valid the cycle after
// synchronous active-high reset clears all sums, counters, flags and the format register (four-bit)
// depends on qbdp_pkg, qbdp_ctrl, qbdp_datapath
module quantized_block_dot_product
   import qbdp_pkg::*;
#(
   parameter int  ACT_WIDTH = 24,
   localparam int REQ_W     = ((58 + 2 * ACT_WIDTH + 7) / 8) * 8
)
(
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   // block_scale, code_byte, fifth_bit_low, fifth_bit_high, half_weight_a, half_weight_b,
   // activation_a, activation_b, zero padding
   input  logic [REQ_W-1:0] req_tdata,
   input  logic             req_tlast,
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   // dot_value
   output logic [63:0]      rsp_tdata,
   // saturated, special_scale
   output logic [1:0]       rsp_tuser,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [1:0]       csr_data
);

   cmd_type    cmd;
   status_type status;

   qbdp_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   qbdp_datapath #(
      .ACT_WIDTH (ACT_WIDTH)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .cmd        (cmd),
      .status     (status)
   );

endmodule
